@@ rtl/rbst_pkg.sv @@
// Package: shared types for the ray/box slab test pipeline.
`default_nettype none
package rbst_pkg;

    // One crossing interval as exact fractions n/d, d > 0.
    typedef struct packed {
        logic               v;
        logic signed [32:0] tmin_n;
        logic        [31:0] tmin_d;
        logic signed [32:0] tmax_n;
        logic        [31:0] tmax_d;
    } span_t;

endpackage
`default_nettype wire

@@ rtl/ray_box_slab_test_unit.sv @@
// Ray versus axis-aligned box hit test, slab method, signed Q16.16.
//
// Input channel s_*: one ray (origin, direction) and one box (min, max
// corners) per word, valid/ready handshake. Output channel m_*: m_hit and
// m_origin_inside for each input word, in order, valid/ready handshake.
// Pipeline: axis setup, merge of x and y, merge with z, final decision.
// Four register stages; the first loads at the accepting edge. Throughput
// is one word per cycle while the receiver does not stall, set by the fully
// pipelined register chain with no stage reused.
// All decisions are exact (cross-multiplied fractions).
// The whole pipeline advances when the output register is empty or taken;
// when the receiver stalls, every stage holds and s_ready drops, so no
// word is lost or repeated. Bubbles in the pipe are not squeezed out.
// Synchronous active-low reset clears all valid bits and holds s_ready
// low; payload registers are not reset.
`default_nettype none
module ray_box_slab_test_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_origin_x,
    input  wire logic signed [31:0] s_origin_y,
    input  wire logic signed [31:0] s_origin_z,
    input  wire logic signed [31:0] s_dir_x,
    input  wire logic signed [31:0] s_dir_y,
    input  wire logic signed [31:0] s_dir_z,
    input  wire logic signed [31:0] s_box_min_x,
    input  wire logic signed [31:0] s_box_min_y,
    input  wire logic signed [31:0] s_box_min_z,
    input  wire logic signed [31:0] s_box_max_x,
    input  wire logic signed [31:0] s_box_max_y,
    input  wire logic signed [31:0] s_box_max_z,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_hit,
    output logic                    m_origin_inside
);
    logic            adv;
    rbst_pkg::span_t ax_x, ax_y, ax_z;
    logic            in_x, in_y, in_z;
    rbst_pkg::span_t mg_xy, mg_all;
    logic            hit_next;

    logic            v1_reg, v2_reg, v3_reg, m_valid_reg;
    rbst_pkg::span_t sx1_reg, sy1_reg, sz1_reg, sxy2_reg, sz2_reg, s3_reg;
    logic            ins1_reg, ins2_reg, ins3_reg;
    logic            zm1_reg, zm2_reg, zm3_reg;
    logic            hit_reg, oin_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv && aresetn;

    rbst_axis u_ax_x (.org(s_origin_x), .dir(s_dir_x), .lo(s_box_min_x),
                      .hi(s_box_max_x), .sp(ax_x), .in_slab(in_x));
    rbst_axis u_ax_y (.org(s_origin_y), .dir(s_dir_y), .lo(s_box_min_y),
                      .hi(s_box_max_y), .sp(ax_y), .in_slab(in_y));
    rbst_axis u_ax_z (.org(s_origin_z), .dir(s_dir_z), .lo(s_box_min_z),
                      .hi(s_box_max_z), .sp(ax_z), .in_slab(in_z));

    rbst_merge u_mg_xy  (.a(sx1_reg), .b(sy1_reg), .y(mg_xy));
    rbst_merge u_mg_all (.a(sxy2_reg), .b(sz2_reg), .y(mg_all));

    rbst_final u_final (.sp(s3_reg), .org_in(ins3_reg), .zmiss(zm3_reg),
                        .hit(hit_next));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sx1_reg  <= ax_x;
            sy1_reg  <= ax_y;
            sz1_reg  <= ax_z;
            ins1_reg <= in_x && in_y && in_z;
            // zero direction outside its slab: miss regardless of the rest
            zm1_reg  <= (!ax_x.v && !in_x) || (!ax_y.v && !in_y) || (!ax_z.v && !in_z);
            sxy2_reg <= mg_xy;
            sz2_reg  <= sz1_reg;
            ins2_reg <= ins1_reg;
            zm2_reg  <= zm1_reg;
            s3_reg   <= mg_all;
            ins3_reg <= ins2_reg;
            zm3_reg  <= zm2_reg;
            hit_reg  <= hit_next;
            oin_reg  <= ins3_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hit           = hit_reg;
    assign m_origin_inside = oin_reg;
endmodule
`default_nettype wire

@@ rtl/rbst_axis.sv @@
// Per-axis slab setup: crossing numerators, denominator and slab membership.
`default_nettype none
module rbst_axis (
    input  wire logic signed [31:0] org,
    input  wire logic signed [31:0] dir,
    input  wire logic signed [31:0] lo,
    input  wire logic signed [31:0] hi,
    output rbst_pkg::span_t         sp,
    output logic                    in_slab
);
    logic signed [32:0] a;
    logic signed [32:0] b;
    logic signed [32:0] n1;
    logic signed [32:0] n2;
    logic               neg;

    always_comb begin
        a       = {lo[31], lo} - {org[31], org};
        b       = {hi[31], hi} - {org[31], org};
        neg     = dir[31];
        n1      = neg ? -a : a;
        n2      = neg ? -b : b;
        in_slab = (lo <= org) && (org <= hi);
        sp.v      = (dir != 32'sd0);
        sp.tmin_n = (n1 < n2) ? n1 : n2;
        sp.tmax_n = (n1 < n2) ? n2 : n1;
        // magnitude; the most negative value maps to 2^31 unsigned
        sp.tmin_d = neg ? 32'(-dir) : 32'(dir);
        sp.tmax_d = sp.tmin_d;
    end
endmodule
`default_nettype wire

@@ rtl/rbst_merge.sv @@
// Merge two intervals: larger lower bound, smaller upper bound; an invalid one yields the other.
`default_nettype none
module rbst_merge (
    input  rbst_pkg::span_t a,
    input  rbst_pkg::span_t b,
    output rbst_pkg::span_t y
);
    logic signed [65:0] lo_b;
    logic signed [65:0] lo_a;
    logic signed [65:0] hi_b;
    logic signed [65:0] hi_a;

    always_comb begin
        lo_b = $signed(b.tmin_n) * $signed({1'b0, a.tmin_d});
        lo_a = $signed(a.tmin_n) * $signed({1'b0, b.tmin_d});
        hi_b = $signed(b.tmax_n) * $signed({1'b0, a.tmax_d});
        hi_a = $signed(a.tmax_n) * $signed({1'b0, b.tmax_d});
        if (!a.v) begin
            y = b;
        end else if (!b.v) begin
            y = a;
        end else begin
            y = a;
            if (lo_b > lo_a) begin
                y.tmin_n = b.tmin_n;
                y.tmin_d = b.tmin_d;
            end
            if (hi_b < hi_a) begin
                y.tmax_n = b.tmax_n;
                y.tmax_d = b.tmax_d;
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/rbst_final.sv @@
// Final decision: empty or behind-origin interval is a miss.
`default_nettype none
module rbst_final (
    input  rbst_pkg::span_t sp,
    input  wire logic       org_in,
    input  wire logic       zmiss,
    output logic            hit
);
    logic signed [65:0] p_lo;
    logic signed [65:0] p_hi;
    logic               miss;

    always_comb begin
        p_lo = $signed(sp.tmin_n) * $signed({1'b0, sp.tmax_d});
        p_hi = $signed(sp.tmax_n) * $signed({1'b0, sp.tmin_d});
        miss = zmiss || (sp.v && (sp.tmax_n < 33'sd0 || p_lo > p_hi));
        hit  = org_in || !miss;
    end
endmodule
`default_nettype wire

@@ rtl/rbst_checker.sv @@
// Port-level checker for the slab test unit, with its bind.
`default_nettype none
module rbst_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_hit,
    input wire logic m_origin_inside
);
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("output valid after reset");

    a_inside_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_origin_inside |-> m_hit) else $error("inside but no hit");

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready)) else $error("s_ready mismatch");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_origin_inside))
        else $error("stalled word changed");
endmodule

bind ray_box_slab_test_unit rbst_checker u_rbst_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready), .m_valid(m_valid),
    .m_ready(m_ready), .m_hit(m_hit), .m_origin_inside(m_origin_inside)
);
`default_nettype wire
